// ----- hw/rtl/ctsc_pkg.sv -----
// Package for the clock time setting controller: types, constants and field step functions.
`timescale 1ns / 1ps

package ctsc_pkg;

   // Field limits and large step sizes
   localparam logic [4:0] HOUR_MAX        = 5'd23;
   localparam logic [5:0] MINUTE_MAX      = 6'd59;
   localparam logic [4:0] HOUR_BIG        = 5'd6;
   localparam logic [5:0] MINUTE_BIG      = 6'd10;
   localparam logic [4:0] HOUR_BIG_WRAP   = 5'd18;   // 24 - 6
   localparam logic [5:0] MINUTE_BIG_WRAP = 6'd50;   // 60 - 10

   // Register reset values
   localparam logic [7:0] TIMEOUT_RESET = 8'd200;
   localparam logic [7:0] HOLD_RESET    = 8'd10;

   // Register indexes
   localparam logic CSR_TIMEOUT_TICKS = 1'b0;
   localparam logic CSR_HOLD_PERIOD   = 1'b1;

   typedef enum logic [1:0] {
      MODE_TICK   = 2'd0,
      MODE_START  = 2'd1,
      MODE_FINISH = 2'd2,
      MODE_IGNORE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      SOUND_NONE   = 2'd0,
      SOUND_START  = 2'd1,
      SOUND_FINISH = 2'd2,
      SOUND_WARN   = 2'd3
   } sound_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       minus_press;
      logic       plus_press;
      logic       minus_hold;
      logic       plus_hold;
      logic       switch_press;
      logic       filter_closed;
      logic       link_up;
      logic [4:0] clock_hour;
      logic [5:0] clock_minute;
   } item_type;

   typedef struct packed {
      logic       active;
      logic       field_sel;
      logic [4:0] edit_hour;
      logic [5:0] edit_minute;
      logic [7:0] timeout_count;
      logic [7:0] hold_count;
      logic       clock_enabled;
   } state_type;

   typedef struct packed {
      logic       editing;
      logic       minute_field;
      logic [4:0] shown_hour;
      logic [5:0] shown_minute;
      logic       commit;
      logic       clock_on;
      sound_type  sound;
   } result_type;

   // Step the hour by 1 or by 6, up or down, with wrap
   function automatic logic [4:0] hour_move(input logic [4:0] hour, input logic up,
                                            input logic big);
      logic [4:0] res;
      if (big) begin
         if (up) res = (hour >= HOUR_BIG_WRAP) ? hour - HOUR_BIG_WRAP : hour + HOUR_BIG;
         else    res = (hour < HOUR_BIG) ? hour + HOUR_BIG_WRAP : hour - HOUR_BIG;
      end else begin
         if (up) res = (hour < HOUR_MAX) ? hour + 5'd1 : 5'd0;
         else    res = (hour != 5'd0) ? hour - 5'd1 : HOUR_MAX;
      end
      return res;
   endfunction

   // Step the minute by 1 or by 10, up or down, with wrap
   function automatic logic [5:0] minute_move(input logic [5:0] minute, input logic up,
                                              input logic big);
      logic [5:0] res;
      if (big) begin
         if (up) res = (minute >= MINUTE_BIG_WRAP) ? minute - MINUTE_BIG_WRAP
                                                   : minute + MINUTE_BIG;
         else    res = (minute < MINUTE_BIG) ? minute + MINUTE_BIG_WRAP
                                             : minute - MINUTE_BIG;
      end else begin
         if (up) res = (minute < MINUTE_MAX) ? minute + 6'd1 : 6'd0;
         else    res = (minute != 6'd0) ? minute - 6'd1 : MINUTE_MAX;
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/ctsc_update.sv -----
// Next-state and result logic for one transfer of the time setting controller.
`timescale 1ns / 1ps

module ctsc_update (
   input  ctsc_pkg::item_type   item,
   input  ctsc_pkg::state_type  state,
   input  logic [7:0]           timeout_ticks,
   input  logic [7:0]           hold_period,
   output ctsc_pkg::state_type  next_state,
   output ctsc_pkg::result_type result
);
   import ctsc_pkg::*;

   always_comb begin : update_proc
      state_type  nxt;
      sound_type  sound;
      logic       commit;
      logic       ended;
      nxt    = state;
      sound  = SOUND_NONE;
      commit = 1'b0;
      ended  = 1'b0;

      case (mode_type'(item.mode))
         MODE_TICK: begin
            // Abort checks: filter open, link up, timeout
            if (nxt.active) begin
               if (!item.filter_closed) begin
                  nxt.active        = 1'b0;
                  nxt.field_sel     = 1'b0;
                  nxt.timeout_count = 8'd0;
               end
               if (item.link_up) begin
                  nxt.active        = 1'b0;
                  nxt.field_sel     = 1'b0;
                  nxt.timeout_count = 8'd0;
                  sound             = SOUND_WARN;
                  ended             = 1'b1;
               end else begin
                  nxt.timeout_count = nxt.timeout_count + 8'd1;
                  if (nxt.timeout_count >= timeout_ticks) begin
                     nxt.active        = 1'b0;
                     nxt.field_sel     = 1'b0;
                     nxt.timeout_count = 8'd0;
                     sound             = SOUND_WARN;
                  end
               end
            end else begin
               nxt.timeout_count = 8'd0;
            end

            // Key events: minus, then plus, then switch
            if (!ended) begin
               if (!nxt.active) begin
                  nxt.hold_count = 8'd0;
               end else begin
                  if (item.minus_press) begin
                     if (nxt.field_sel) nxt.edit_minute = minute_move(nxt.edit_minute, 1'b0, 1'b0);
                     else               nxt.edit_hour   = hour_move(nxt.edit_hour, 1'b0, 1'b0);
                  end else if (item.minus_hold) begin
                     nxt.hold_count = nxt.hold_count + 8'd1;
                     if (nxt.hold_count >= hold_period) begin
                        nxt.hold_count = 8'd0;
                        if (nxt.field_sel) nxt.edit_minute = minute_move(nxt.edit_minute, 1'b0, 1'b1);
                        else               nxt.edit_hour   = hour_move(nxt.edit_hour, 1'b0, 1'b1);
                     end
                  end
                  if (item.plus_press) begin
                     if (nxt.field_sel) nxt.edit_minute = minute_move(nxt.edit_minute, 1'b1, 1'b0);
                     else               nxt.edit_hour   = hour_move(nxt.edit_hour, 1'b1, 1'b0);
                  end else if (item.plus_hold) begin
                     nxt.hold_count = nxt.hold_count + 8'd1;
                     if (nxt.hold_count >= hold_period) begin
                        nxt.hold_count = 8'd0;
                        if (nxt.field_sel) nxt.edit_minute = minute_move(nxt.edit_minute, 1'b1, 1'b1);
                        else               nxt.edit_hour   = hour_move(nxt.edit_hour, 1'b1, 1'b1);
                     end
                  end
                  if (item.switch_press) begin
                     nxt.field_sel = ~nxt.field_sel;
                  end
               end
            end
         end
         MODE_START: begin
            // Load the clock time, clamped, unless the link blocks editing
            if (item.link_up) begin
               sound = SOUND_WARN;
            end else begin
               sound           = SOUND_START;
               nxt.active      = 1'b1;
               nxt.field_sel   = 1'b0;
               nxt.edit_hour   = (item.clock_hour > HOUR_MAX) ? HOUR_MAX : item.clock_hour;
               nxt.edit_minute = (item.clock_minute > MINUTE_MAX) ? MINUTE_MAX
                                                                  : item.clock_minute;
            end
         end
         MODE_FINISH: begin
            // Commit, or switch the clock off at midnight
            if (nxt.active) begin
               if (nxt.edit_hour == 5'd0 && nxt.edit_minute == 6'd0) begin
                  nxt.clock_enabled = 1'b0;
               end else begin
                  commit            = 1'b1;
                  nxt.clock_enabled = 1'b1;
               end
               nxt.active    = 1'b0;
               nxt.field_sel = 1'b0;
               sound         = SOUND_FINISH;
            end
         end
         MODE_IGNORE: begin
            nxt = state;
         end
         default: begin
            nxt = state;
         end
      endcase

      next_state          = nxt;
      result.editing      = nxt.active;
      result.minute_field = nxt.field_sel;
      result.shown_hour   = nxt.edit_hour;
      result.shown_minute = nxt.edit_minute;
      result.commit       = commit;
      result.clock_on     = nxt.clock_enabled;
      result.sound        = sound;
   end

endmodule

// ----- hw/rtl/clock_time_setting_controller.sv -----
// Top level of the clock time setting controller: input register, state and result register.
`timescale 1ns / 1ps

// Takes one transfer per clock and returns exactly one result per transfer. A request
// lands in the input register; when the result register is free or being emptied, the edit
// state is updated from it and the result is held in the result register. The sustained
// rate is one transfer per clock, limited only by the result side taking results. Registers
// timeout_ticks (index 0) and hold_period (index 1) should be written only while no transfer
// is in flight.
module clock_time_setting_controller (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic       req_minus_press,
   input  logic       req_plus_press,
   input  logic       req_minus_hold,
   input  logic       req_plus_hold,
   input  logic       req_switch_press,
   input  logic       req_filter_closed,
   input  logic       req_link_up,
   input  logic [4:0] req_clock_hour,
   input  logic [5:0] req_clock_minute,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_editing,
   output logic       rsp_minute_field,
   output logic [4:0] rsp_shown_hour,
   output logic [5:0] rsp_shown_minute,
   output logic       rsp_commit,
   output logic       rsp_clock_on,
   output logic [1:0] rsp_sound,
   // configuration port
   input  logic       csr_write_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);
   import ctsc_pkg::*;

   logic [7:0] timeout_ticks_ff;
   logic [7:0] hold_period_ff;
   logic       item_valid_ff;
   item_type   item_ff;
   state_type  state_ff;
   state_type  state_in;
   logic       rsp_valid_ff;
   result_type result_ff;
   result_type result_in;
   logic       advance;

   // Move the held item on when the result register is free or being emptied
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ticks_ff <= TIMEOUT_RESET;
         hold_period_ff   <= HOLD_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wdata;
            CSR_HOLD_PERIOD:   hold_period_ff   <= csr_wdata;
            default:           timeout_ticks_ff <= timeout_ticks_ff;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.mode          <= req_mode;
         item_ff.minus_press   <= req_minus_press;
         item_ff.plus_press    <= req_plus_press;
         item_ff.minus_hold    <= req_minus_hold;
         item_ff.plus_hold     <= req_plus_hold;
         item_ff.switch_press  <= req_switch_press;
         item_ff.filter_closed <= req_filter_closed;
         item_ff.link_up       <= req_link_up;
         item_ff.clock_hour    <= req_clock_hour;
         item_ff.clock_minute  <= req_clock_minute;
      end
   end

   ctsc_update u_update (
      .item          (item_ff),
      .state         (state_ff),
      .timeout_ticks (timeout_ticks_ff),
      .hold_period   (hold_period_ff),
      .next_state    (state_in),
      .result        (result_in)
   );

   // Edit state, updated once per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_editing      = result_ff.editing;
   assign rsp_minute_field = result_ff.minute_field;
   assign rsp_shown_hour   = result_ff.shown_hour;
   assign rsp_shown_minute = result_ff.shown_minute;
   assign rsp_commit       = result_ff.commit;
   assign rsp_clock_on     = result_ff.clock_on;
   assign rsp_sound        = result_ff.sound;

endmodule

// ----- hw/rtl/ctsc_checker.sv -----
// Port checker for the clock time setting controller and its bind.
`timescale 1ns / 1ps

module ctsc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_editing,
   input logic       rsp_minute_field,
   input logic [4:0] rsp_shown_hour,
   input logic [5:0] rsp_shown_minute,
   input logic       rsp_commit,
   input logic       rsp_clock_on,
   input logic [1:0] rsp_sound
);
   import ctsc_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_commit) && $stable(rsp_sound)
         && $stable(rsp_shown_hour) && $stable(rsp_shown_minute))
      else $error("stalled result changed");

   // A commit only comes with the finish voice, editing ended and the clock on
   a_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_commit |-> rsp_sound == SOUND_FINISH && rsp_clock_on && !rsp_editing)
      else $error("commit without finish");

   // Finish always leaves editing
   a_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sound == SOUND_FINISH |-> !rsp_editing && !rsp_minute_field)
      else $error("finish left editing active");

   // Start voice means editing on the hour field
   a_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sound == SOUND_START |-> rsp_editing && !rsp_minute_field)
      else $error("start did not enter editing");

   // Edited time stays in range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_editing |-> rsp_shown_hour <= HOUR_MAX && rsp_shown_minute <= MINUTE_MAX)
      else $error("edited time out of range");

endmodule

bind clock_time_setting_controller ctsc_checker u_ctsc_checker (.*);

// ----- tb/tb_clock_time_setting_controller.sv -----
// Self-checking testbench for the clock time setting controller: stimulus, prediction and checks.
`timescale 1ns / 1ps

module tb_clock_time_setting_controller;
   import ctsc_pkg::*;

   localparam int STALL_PCT   = 36;
   localparam int QUIET_LIMIT = 5000;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 140;
   localparam int ITEM_W      = $bits(item_type);

   typedef struct {
      item_type fields;
      bit       drain;
   } request_entry_type;

   logic       clock        = 1'b0;
   logic       reset        = 1'b1;
   logic       req_valid    = 1'b0;
   logic       req_ready;
   item_type   req_item     = '0;
   logic       rsp_valid;
   logic       rsp_ready    = 1'b0;
   logic       rsp_editing;
   logic       rsp_minute_field;
   logic [4:0] rsp_shown_hour;
   logic [5:0] rsp_shown_minute;
   logic       rsp_commit;
   logic       rsp_clock_on;
   logic [1:0] rsp_sound;
   logic       csr_write_en = 1'b0;
   logic       csr_index    = 1'b0;
   logic [7:0] csr_wdata    = 8'd0;

   // Shadow of the edit state and of the registers
   logic       shadow_active      = 1'b0;
   logic       shadow_minute_sel  = 1'b0;
   logic [4:0] shadow_hour        = '0;
   logic [5:0] shadow_minute      = '0;
   logic [7:0] shadow_timeout_cnt = '0;
   logic [7:0] shadow_hold_cnt    = '0;
   logic       shadow_clock_on    = 1'b0;
   logic [7:0] cfg_timeout_ticks  = TIMEOUT_RESET;
   logic [7:0] cfg_hold_period    = HOLD_RESET;

   request_entry_type pending_requests[$];
   result_type        expected_displays[$];
   int                requests_queued = 0;
   int                requests_taken  = 0;
   int                mismatches      = 0;
   int                quiet_cycles    = 0;
   logic              req_took        = 1'b0;
   logic              calm_run        = 1'b0;

   clock_time_setting_controller u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_item.mode),
      .req_minus_press   (req_item.minus_press),
      .req_plus_press    (req_item.plus_press),
      .req_minus_hold    (req_item.minus_hold),
      .req_plus_hold     (req_item.plus_hold),
      .req_switch_press  (req_item.switch_press),
      .req_filter_closed (req_item.filter_closed),
      .req_link_up       (req_item.link_up),
      .req_clock_hour    (req_item.clock_hour),
      .req_clock_minute  (req_item.clock_minute),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_editing       (rsp_editing),
      .rsp_minute_field  (rsp_minute_field),
      .rsp_shown_hour    (rsp_shown_hour),
      .rsp_shown_minute  (rsp_shown_minute),
      .rsp_commit        (rsp_commit),
      .rsp_clock_on      (rsp_clock_on),
      .rsp_sound         (rsp_sound),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Move the selected field by 1 or by a large step, wrapping round the day or the hour
   function automatic void move_field(bit up, bit big);
      int span;
      int val;
      if (!shadow_minute_sel) begin
         span = big ? 6 : 1;
         val  = (shadow_hour + (up ? span : 24 - span)) % 24;
         shadow_hour = val[4:0];
      end else begin
         span = big ? 10 : 1;
         val  = (shadow_minute + (up ? span : 60 - span)) % 60;
         shadow_minute = val[5:0];
      end
   endfunction

   // Count a held tick; take the large step once the hold period is reached
   function automatic void held_step(bit up);
      shadow_hold_cnt = shadow_hold_cnt + 8'd1;
      if (shadow_hold_cnt >= cfg_hold_period) begin
         shadow_hold_cnt = '0;
         move_field(up, 1'b1);
      end
   endfunction

   function automatic void cancel_edit();
      shadow_active      = 1'b0;
      shadow_minute_sel  = 1'b0;
      shadow_timeout_cnt = '0;
   endfunction

   // Advance the shadow state by one request and return the display it should produce
   function automatic result_type apply_setting_request(item_type req);
      result_type res;
      sound_type  tone;
      bit         done;
      bit         wrote;
      tone  = SOUND_NONE;
      done  = 1'b0;
      wrote = 1'b0;
      case (mode_type'(req.mode))
         MODE_TICK: begin
            // abort checks: open filter, link up, then the timeout
            if (shadow_active) begin
               if (!req.filter_closed) cancel_edit();
               if (req.link_up) begin
                  cancel_edit();
                  tone = SOUND_WARN;
                  done = 1'b1;
               end else begin
                  shadow_timeout_cnt = shadow_timeout_cnt + 8'd1;
                  if (shadow_timeout_cnt >= cfg_timeout_ticks) begin
                     cancel_edit();
                     tone = SOUND_WARN;
                  end
               end
            end else begin
               shadow_timeout_cnt = '0;
            end
            // key events only count while editing survives
            if (!done) begin
               if (!shadow_active) begin
                  shadow_hold_cnt = '0;
               end else begin
                  if (req.minus_press) move_field(1'b0, 1'b0);
                  else if (req.minus_hold) held_step(1'b0);
                  if (req.plus_press) move_field(1'b1, 1'b0);
                  else if (req.plus_hold) held_step(1'b1);
                  if (req.switch_press) shadow_minute_sel = ~shadow_minute_sel;
               end
            end
         end
         MODE_START: begin
            if (req.link_up) begin
               tone = SOUND_WARN;
            end else begin
               tone              = SOUND_START;
               shadow_active     = 1'b1;
               shadow_minute_sel = 1'b0;
               shadow_hour   = (req.clock_hour > HOUR_MAX) ? HOUR_MAX : req.clock_hour;
               shadow_minute = (req.clock_minute > MINUTE_MAX) ? MINUTE_MAX : req.clock_minute;
            end
         end
         MODE_FINISH: begin
            if (shadow_active) begin
               if (shadow_hour == '0 && shadow_minute == '0) begin
                  shadow_clock_on = 1'b0;
               end else begin
                  wrote           = 1'b1;
                  shadow_clock_on = 1'b1;
               end
               shadow_active     = 1'b0;
               shadow_minute_sel = 1'b0;
               tone              = SOUND_FINISH;
            end
         end
         default: ;
      endcase
      res.editing      = shadow_active;
      res.minute_field = shadow_minute_sel;
      res.shown_hour   = shadow_hour;
      res.shown_minute = shadow_minute;
      res.commit       = wrote;
      res.clock_on     = shadow_clock_on;
      res.sound        = tone;
      return res;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Request driver: hold an offered transfer until taken, otherwise offer the next or idle
   always @(negedge clock) begin
      request_entry_type nxt;
      rsp_ready <= calm_run || ($urandom_range(99) >= STALL_PCT);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_requests.size() != 0 &&
             !(pending_requests[0].drain && expected_displays.size() != 0) &&
             (calm_run || $urandom_range(99) >= STALL_PCT)) begin
            nxt = pending_requests.pop_front();
            req_item  <= nxt.fields;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: predict on each request transfer, check each result transfer
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            expected_displays.push_back(apply_setting_request(req_item));
            requests_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_displays.size() == 0) begin
               $error("result transfer with no display expected");
               mismatches++;
            end else begin
               want = expected_displays.pop_front();
               check_field("editing", int'(want.editing), int'(rsp_editing));
               check_field("minute_field", int'(want.minute_field), int'(rsp_minute_field));
               check_field("shown_hour", int'(want.shown_hour), int'(rsp_shown_hour));
               check_field("shown_minute", int'(want.shown_minute), int'(rsp_shown_minute));
               check_field("commit", int'(want.commit), int'(rsp_commit));
               check_field("clock_on", int'(want.clock_on), int'(rsp_clock_on));
               check_field("sound", int'(want.sound), int'(rsp_sound));
            end
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void queue_request(item_type f, bit drain);
      request_entry_type q;
      q.fields = f;
      q.drain  = drain;
      pending_requests.push_back(q);
      requests_queued++;
   endfunction

   function automatic item_type key_tick(bit mp, bit pp, bit mh, bit ph, bit sw);
      item_type r;
      r               = '0;
      r.mode          = MODE_TICK;
      r.filter_closed = 1'b1;
      r.minus_press   = mp;
      r.plus_press    = pp;
      r.minus_hold    = mh;
      r.plus_hold     = ph;
      r.switch_press  = sw;
      return r;
   endfunction

   function automatic item_type start_at(logic [4:0] hour, logic [5:0] minute);
      item_type r;
      r              = '0;
      r.mode         = MODE_START;
      r.clock_hour   = hour;
      r.clock_minute = minute;
      return r;
   endfunction

   function automatic item_type finish_req();
      item_type r;
      r      = '0;
      r.mode = MODE_FINISH;
      return r;
   endfunction

   function automatic bit drain_roll();
      return $urandom_range(79) == 0;
   endfunction

   // One editing session: start, a run of ticks with random keys, then finish
   task automatic queue_edit_session();
      item_type r;
      int       ticks;
      bit [1:0] held;
      bit       zero_run;
      zero_run = ($urandom_range(9) == 0);
      held     = 2'($urandom_range(3));
      ticks    = ($urandom_range(7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      r         = ITEM_W'($urandom);
      r.mode    = MODE_START;
      r.link_up = ($urandom_range(19) == 0);
      if (zero_run) begin
         r.clock_hour   = '0;
         r.clock_minute = '0;
      end else if ($urandom_range(9) != 0) begin
         r.clock_hour   = 5'($urandom_range(23));
         r.clock_minute = 6'($urandom_range(59));
      end
      queue_request(r, drain_roll());
      repeat (ticks) begin
         r               = ITEM_W'($urandom);
         r.mode          = MODE_TICK;
         r.filter_closed = ($urandom_range(49) != 0);
         r.link_up       = ($urandom_range(59) == 0);
         r.minus_press   = !zero_run && ($urandom_range(6) == 0);
         r.plus_press    = !zero_run && ($urandom_range(6) == 0);
         r.minus_hold    = !zero_run && held[0] && ($urandom_range(9) != 0);
         r.plus_hold     = !zero_run && held[1] && ($urandom_range(9) != 0);
         r.switch_press  = !zero_run && ($urandom_range(9) == 0);
         // occasional restart in the middle of a session
         if (!zero_run && $urandom_range(39) == 0) begin
            r.mode    = MODE_START;
            r.link_up = 1'b0;
         end
         queue_request(r, drain_roll());
      end
      r      = ITEM_W'($urandom);
      r.mode = MODE_FINISH;
      queue_request(r, drain_roll());
   endtask

   task automatic write_settings(logic [7:0] timeout, logic [7:0] hold);
      @(negedge clock);
      csr_write_en      <= 1'b1;
      csr_index         <= CSR_TIMEOUT_TICKS;
      csr_wdata         <= timeout;
      cfg_timeout_ticks = timeout;
      @(negedge clock);
      csr_index         <= CSR_HOLD_PERIOD;
      csr_wdata         <= hold;
      cfg_hold_period   = hold;
      @(negedge clock);
      csr_write_en      <= 1'b0;
   endtask

   task automatic wait_all_answered();
      while (requests_taken != requests_queued || expected_displays.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      int       timeouts[PHASES];
      int       holds[PHASES];
      item_type r;
      int       target;

      timeouts = '{200, 255, 1, 7, 0, 30, 255, 2, 0, 0};
      holds    = '{10, 255, 1, 3, 0, 1, 5, 0, 0, 0};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field wraps, held steps, restart, both finish outcomes and aborts
      write_settings(8'd255, 8'd2);
      queue_request(key_tick(1, 1, 1, 1, 1), 1'b0);   // keys ignored while idle
      queue_request(finish_req(), 1'b0);              // finish while idle
      r = '1;
      r.mode = MODE_IGNORE;
      queue_request(r, 1'b0);
      r = start_at(5'd3, 6'd4);
      r.link_up = 1'b1;
      queue_request(r, 1'b0);                         // start refused, link up
      queue_request(start_at(5'd31, 6'd63), 1'b1);    // clamp, after a full drain
      queue_request(key_tick(0, 1, 0, 0, 0), 1'b0);
      queue_request(key_tick(1, 0, 0, 0, 0), 1'b0);
      queue_request(key_tick(0, 0, 1, 0, 0), 1'b0);
      queue_request(key_tick(0, 0, 1, 0, 0), 1'b0);
      queue_request(key_tick(0, 0, 0, 1, 0), 1'b0);
      queue_request(key_tick(0, 0, 0, 1, 0), 1'b0);
      queue_request(key_tick(0, 0, 0, 0, 1), 1'b0);
      queue_request(key_tick(0, 1, 0, 0, 0), 1'b0);
      queue_request(key_tick(1, 0, 0, 0, 0), 1'b0);
      queue_request(key_tick(0, 0, 1, 1, 0), 1'b0);
      queue_request(key_tick(1, 1, 1, 1, 1), 1'b0);
      queue_request(start_at(5'd0, 6'd0), 1'b0);      // restart while editing
      queue_request(finish_req(), 1'b0);              // midnight turns the clock off
      queue_request(start_at(5'd12, 6'd34), 1'b0);
      queue_request(finish_req(), 1'b0);              // commit
      queue_request(start_at(5'd8, 6'd15), 1'b0);
      queue_request(key_tick(0, 0, 0, 0, 0), 1'b0);
      r = key_tick(0, 1, 0, 0, 0);
      r.filter_closed = 1'b0;
      queue_request(r, 1'b0);                         // silent abort
      queue_request(start_at(5'd20, 6'd45), 1'b0);
      r = key_tick(0, 1, 0, 0, 0);
      r.link_up = 1'b1;
      queue_request(r, 1'b0);                         // abort with warning
      queue_request(key_tick(0, 0, 0, 0, 0), 1'b0);
      wait_all_answered();

      // Directed: zero timeout aborts on the first tick
      write_settings(8'd0, 8'd0);
      queue_request(start_at(5'd1, 6'd2), 1'b0);
      queue_request(key_tick(0, 0, 0, 1, 0), 1'b0);
      wait_all_answered();

      // Directed: filter abort still counts one tick, so a timeout of one warns
      write_settings(8'd1, 8'd0);
      queue_request(start_at(5'd9, 6'd9), 1'b0);
      r = key_tick(0, 0, 0, 0, 0);
      r.filter_closed = 1'b0;
      queue_request(r, 1'b0);
      wait_all_answered();

      // Directed: zero hold period steps on every held tick until the timeout ends editing
      write_settings(8'd3, 8'd0);
      queue_request(start_at(5'd5, 6'd5), 1'b0);
      queue_request(key_tick(0, 0, 1, 0, 0), 1'b0);
      queue_request(key_tick(0, 0, 0, 1, 1), 1'b0);
      queue_request(key_tick(0, 0, 1, 0, 0), 1'b0);
      wait_all_answered();

      // Random phases, each under its own register setting
      timeouts[PHASES-2] = int'($urandom_range(255));
      holds[PHASES-2]    = int'($urandom_range(255));
      timeouts[PHASES-1] = int'($urandom_range(1, 40));
      holds[PHASES-1]    = int'($urandom_range(1, 12));
      for (int p = 0; p < PHASES; p++) begin
         write_settings(timeouts[p][7:0], holds[p][7:0]);
         calm_run = (p == 3);
         target   = requests_queued + PHASE_ITEMS;
         while (requests_queued < target) begin
            if ($urandom_range(99) < 15) begin
               r = ITEM_W'($urandom);
               queue_request(r, drain_roll());
            end else begin
               queue_edit_session();
            end
         end
         wait_all_answered();
         calm_run = 1'b0;
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
